// ===== rtl/afb_pkg.sv =====
package afb_pkg;

  typedef logic [4:0] pos_t;

  typedef struct packed {
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic [31:0] roll_bits;
  } payload_t;

  // Head of the queue as seen by the serializer.
  typedef struct packed {
    logic     valid;
    payload_t data;
  } queue_head_t;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] LEN_VALUE   = 8'd12;
  localparam logic [7:0] TYPE_VALUE  = 8'h02;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  localparam pos_t POS_SYNC_FIRST   = 5'd0;
  localparam pos_t POS_SYNC_SECOND  = 5'd1;
  localparam pos_t POS_LEN          = 5'd2;
  localparam pos_t POS_TYPE         = 5'd3;
  localparam pos_t POS_PAYLOAD      = 5'd4;
  localparam pos_t POS_LAST_PAYLOAD = 5'd15;
  localparam pos_t POS_CRC          = 5'd16;

  // One byte through the MSB-first CRC-8 with polynomial 0x07.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Frame byte at a header or payload position.
  function automatic logic [7:0] frame_byte_at(pos_t pos, payload_t p);
    logic [3:0] idx;
    logic [7:0] r;
    idx = 4'(pos - POS_PAYLOAD);
    unique case (pos)
      POS_SYNC_FIRST:  r = SYNC_FIRST;
      POS_SYNC_SECOND: r = SYNC_SECOND;
      POS_LEN:         r = LEN_VALUE;
      POS_TYPE:        r = TYPE_VALUE;
      default: begin
        if (pos > POS_LAST_PAYLOAD) begin
          r = 8'h00;
        end else begin
          r = p[{idx, 3'b000} +: 8];
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/afb_in_if.sv =====
interface afb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] roll_bits;
  logic [31:0] pitch_bits;
  logic [31:0] yaw_bits;

  modport source (output valid, output roll_bits, output pitch_bits, output yaw_bits,
                  input ready);
  modport sink (input valid, input roll_bits, input pitch_bits, input yaw_bits,
                output ready);
endinterface

// ===== rtl/afb_out_if.sv =====
interface afb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/attitude_frame_builder_crc8.sv =====
// Attitude telemetry frame builder.
// The in_ch channel takes one transaction per attitude sample: the raw
// 32-bit patterns of roll, pitch and yaw. For every transaction the block
// sends a 17-byte frame on out_ch, one byte per transaction: 0xAA, 0x55,
// length 12, type 0x02, the three words least significant byte first, and
// a CRC-8 (polynomial 0x07, init 0) over the length, type and payload bytes.
// The final CRC byte carries last_byte high.
// Accepted samples wait in a small queue of QUEUE_DEPTH entries, so the
// input side keeps taking samples while a frame is still being sent.
// On an idle block the serializer loads an accepted sample from the queue
// and then registers the first frame byte. It sends one byte per cycle while
// out_ch.ready is high and, when the next sample is already queued, starts
// the next frame right after the CRC byte, so frames follow with no gap.
// When the receiver holds out_ch.ready low, the current byte stays on the
// port and the serializer waits; once the queue fills, in_ch.ready falls.
// Synchronous reset empties the queue, drops any frame in flight and
// clears the output valid.
module attitude_frame_builder_crc8 #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst,
  afb_in_if.sink    in_ch,
  afb_out_if.source out_ch
);

  // Head of the sample queue and the serializer's request for it.
  afb_pkg::queue_head_t head;
  logic                 pop;

  // Front end: accepts samples and queues them.
  afb_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .in_ch(in_ch),
    .head (head),
    .pop  (pop)
  );

  // Back end: walks the frame one byte per cycle while out_ch is not stalled and folds the CRC.
  afb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

// ===== rtl/afb_front.sv =====
module afb_front #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  afb_in_if.sink               in_ch,
  output afb_pkg::queue_head_t head,
  input  logic                 pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  afb_pkg::payload_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          do_pop;

  assign in_ch.ready = (count != CW'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{yaw_bits: in_ch.yaw_bits, pitch_bits: in_ch.pitch_bits,
                       roll_bits: in_ch.roll_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/afb_back.sv =====
module afb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  afb_pkg::queue_head_t head,
  output logic                 pop,
  afb_out_if.source            out_ch
);

  logic              active;
  logic              active_next;
  afb_pkg::pos_t     pos;
  afb_pkg::pos_t     pos_next;
  logic [7:0]        crc;
  logic [7:0]        crc_next;
  afb_pkg::payload_t hold;
  afb_pkg::payload_t hold_next;
  logic              ovalid;
  logic              ovalid_next;
  logic [7:0]        obyte;
  logic [7:0]        obyte_next;
  logic              olast;
  logic              olast_next;
  logic              out_load;
  logic [7:0]        b;

  assign out_ch.valid      = ovalid;
  assign out_ch.frame_byte = obyte;
  assign out_ch.last_byte  = olast;
  assign out_load          = !ovalid || out_ch.ready;

  always_comb begin
    active_next = active;
    pos_next    = pos;
    crc_next    = crc;
    hold_next   = hold;
    ovalid_next = ovalid;
    obyte_next  = obyte;
    olast_next  = olast;
    pop         = 1'b0;
    b           = afb_pkg::frame_byte_at(pos, hold);

    if (out_load) begin
      ovalid_next = active;
    end

    if (active && out_load) begin
      if (pos == afb_pkg::POS_CRC) begin
        obyte_next = crc;
        olast_next = 1'b1;
        if (head.valid) begin
          pop       = 1'b1;
          hold_next = head.data;
          pos_next  = afb_pkg::POS_SYNC_FIRST;
          crc_next  = 8'h00;
        end else begin
          active_next = 1'b0;
        end
      end else begin
        obyte_next = b;
        olast_next = 1'b0;
        if (pos >= afb_pkg::POS_LEN) begin
          crc_next = afb_pkg::crc8_update(crc, b);
        end
        pos_next = pos + 1'b1;
      end
    end else if (!active && head.valid) begin
      pop         = 1'b1;
      hold_next   = head.data;
      active_next = 1'b1;
      pos_next    = afb_pkg::POS_SYNC_FIRST;
      crc_next    = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    hold  <= hold_next;
    obyte <= obyte_next;
    olast <= olast_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
      crc    <= 8'h00;
      ovalid <= 1'b0;
    end else begin
      active <= active_next;
      pos    <= pos_next;
      crc    <= crc_next;
      ovalid <= ovalid_next;
    end
  end

endmodule
